FILE: hdl/rcc_pkg.sv
// shared types, constants and crc/hex helpers for the reply crc checker
`default_nettype none

package rcc_pkg;

   // longest text reply before a missing carriage return is reported
   localparam logic [15:0] MAX_TEXT_LEN = 16'd1024;

   localparam logic [7:0]  CR_CHAR   = 8'h0D;
   localparam logic [7:0]  BIN_SYNC0 = 8'hC4;
   localparam logic [7:0]  BIN_SYNC1 = 8'hA5;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TEXT,
      PH_BHDR,
      PH_BBODY,
      PH_BTAIL,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_HDR_BAD  = 3'd1,
      ST_BODY_BAD = 3'd2,
      ST_TEXT_BAD = 3'd3,
      ST_NO_CR    = 3'd4,
      ST_SHORT    = 3'd5
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        is_binary;
      logic [15:0] computed_crc;
      logic [15:0] received_crc;
      logic [15:0] message_length;
   } result_type;

   // crc-16/arc update by one byte, reflected, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // crc after the binary sync pair
   localparam logic [15:0] CRC_SYNC = crc_byte(crc_byte(16'h0000, BIN_SYNC0), BIN_SYNC1);

   // hex digit value in [3:0], bit 4 set when the character is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] v;
      v = 5'b1_0000;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         v = {1'b0, ch[3:0]};
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         v = {1'b0, 4'(ch[3:0] + 4'd9)};
      end
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/reply_crc_checker_top.sv
// reply crc checker top level: input register, framing logic, result register
// a result is registered in the result register as its completing byte leaves the input register
// throughput: one byte per cycle unless stalled, set by the combinational crc update in the fsm
// a result waiting in the output register stalls framing; one more byte is held, then input stalls
// reset: synchronous, active high; clears the valid flags and returns framing to idle
// after reset, bytes are ignored until one arrives with start_of_message set
`default_nettype none

module reply_crc_checker_top
   import rcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic             rsp_is_binary,
   output logic [15:0]      rsp_computed_crc,
   output logic [15:0]      rsp_received_crc,
   output logic [15:0]      rsp_message_length
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_som_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       fire;
   logic       emit;
   result_type result;

   // the framing stage advances when the result register has room
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // input register
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_som_ff  <= req_start_of_message;
      end
   end

   rcc_frame_fsm u_fsm (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .data_byte        (in_data_ff),
      .start_of_message (in_som_ff),
      .emit             (emit),
      .result           (result)
   );

   // result register
   assign out_valid_in = fire ? emit : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_is_binary      = out_ff.is_binary;
   assign rsp_computed_crc   = out_ff.computed_crc;
   assign rsp_received_crc   = out_ff.received_crc;
   assign rsp_message_length = out_ff.message_length;

endmodule

`default_nettype wire

FILE: hdl/rcc_frame_fsm.sv
// message framing state machine with crc check and verdict logic
`default_nettype none

module rcc_frame_fsm
   import rcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] data_byte,
   input  wire logic       start_of_message,
   output logic            emit,
   output result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  win_ff [4];
   logic [7:0]  win_in [4];
   logic [15:0] count_ff, count_in;
   logic [15:0] blen_ff, blen_in;
   logic [7:0]  carried_lo_ff, carried_lo_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (fire) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         crc_ff        <= crc_in;
         win_ff        <= win_in;
         count_ff      <= count_in;
         blen_ff       <= blen_in;
         carried_lo_ff <= carried_lo_in;
      end
   end

   // next state and verdict
   always_comb begin
      phase_type   c_phase;
      logic [15:0] c_crc;
      logic [7:0]  c_win [4];
      logic [15:0] c_count;
      logic [15:0] c_blen;
      logic [7:0]  c_lo;
      logic [7:0]  crc_data;
      logic [15:0] crc_next;
      logic [15:0] count_inc;
      logic [4:0]  h0, h1, h2, h3;
      logic [15:0] recv_text;
      logic        hex_bad;
      logic [15:0] recv_bin;

      // a start flag opens a fresh message with this byte
      if (start_of_message) begin
         c_phase = PH_TEXT;
         c_crc   = 16'h0000;
         c_win   = '{default: 8'h00};
         c_count = 16'h0000;
         c_blen  = 16'h0000;
         c_lo    = 8'h00;
      end else begin
         c_phase = phase_ff;
         c_crc   = crc_ff;
         c_win   = win_ff;
         c_count = count_ff;
         c_blen  = blen_ff;
         c_lo    = carried_lo_ff;
      end

      // one shared crc byte update; text delays its input by four characters
      crc_data  = (c_phase == PH_TEXT) ? c_win[0] : data_byte;
      crc_next  = crc_byte(c_crc, crc_data);
      count_inc = c_count + 16'd1;

      h0 = hex_value(c_win[0]);
      h1 = hex_value(c_win[1]);
      h2 = hex_value(c_win[2]);
      h3 = hex_value(c_win[3]);
      recv_text = {h0[3:0], h1[3:0], h2[3:0], h3[3:0]};
      hex_bad   = h0[4] | h1[4] | h2[4] | h3[4];
      recv_bin  = {data_byte, c_lo};

      phase_in      = c_phase;
      crc_in        = c_crc;
      win_in        = c_win;
      count_in      = c_count;
      blen_in       = c_blen;
      carried_lo_in = c_lo;
      emit          = 1'b0;
      result        = '{status: ST_OK, is_binary: 1'b0, computed_crc: 16'h0000,
                        received_crc: 16'h0000, message_length: 16'h0000};

      unique case (c_phase)
         PH_TEXT: begin
            if (c_count == 16'd1 && c_win[3] == BIN_SYNC0 && data_byte == BIN_SYNC1) begin
               phase_in = PH_BHDR;
               crc_in   = CRC_SYNC;
               count_in = 16'd2;
            end else if (data_byte == CR_CHAR) begin
               emit     = 1'b1;
               phase_in = PH_DONE;
               if (c_count < 16'd4) begin
                  result.status         = ST_SHORT;
                  result.message_length = c_count;
               end else begin
                  result.status         = (hex_bad || recv_text != c_crc) ? ST_TEXT_BAD
                                                                           : ST_OK;
                  result.computed_crc   = c_crc;
                  result.received_crc   = recv_text;
                  result.message_length = c_count;
               end
            end else begin
               if (c_count >= 16'd4) begin
                  crc_in = crc_next;
               end
               win_in   = '{c_win[1], c_win[2], c_win[3], data_byte};
               count_in = count_inc;
               if (count_inc >= MAX_TEXT_LEN) begin
                  emit                  = 1'b1;
                  phase_in              = PH_DONE;
                  result.status         = ST_NO_CR;
                  result.message_length = MAX_TEXT_LEN;
               end
            end
         end
         PH_BHDR: begin
            unique case (c_count)
               16'd2: begin
                  blen_in  = {8'h00, data_byte};
                  crc_in   = crc_next;
                  count_in = count_inc;
               end
               16'd3: begin
                  blen_in  = {data_byte, c_blen[7:0]};
                  crc_in   = crc_next;
                  count_in = count_inc;
               end
               16'd4: begin
                  carried_lo_in = data_byte;
                  count_in      = count_inc;
               end
               default: begin
                  if (recv_bin != c_crc) begin
                     emit                  = 1'b1;
                     phase_in              = PH_DONE;
                     result.status         = ST_HDR_BAD;
                     result.is_binary      = 1'b1;
                     result.computed_crc   = c_crc;
                     result.received_crc   = recv_bin;
                     result.message_length = c_blen;
                  end else begin
                     crc_in   = 16'h0000;
                     count_in = 16'h0000;
                     phase_in = (c_blen == 16'h0000) ? PH_BTAIL : PH_BBODY;
                  end
               end
            endcase
         end
         PH_BBODY: begin
            crc_in   = crc_next;
            count_in = count_inc;
            if (count_inc == c_blen) begin
               count_in = 16'h0000;
               phase_in = PH_BTAIL;
            end
         end
         PH_BTAIL: begin
            if (c_count == 16'h0000) begin
               carried_lo_in = data_byte;
               count_in      = 16'd1;
            end else begin
               emit                  = 1'b1;
               phase_in              = PH_DONE;
               result.status         = (recv_bin != c_crc) ? ST_BODY_BAD : ST_OK;
               result.is_binary      = 1'b1;
               result.computed_crc   = c_crc;
               result.received_crc   = recv_bin;
               result.message_length = c_blen;
            end
         end
         default: begin
            // idle or verdict given: bytes are dropped
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/rcc_checker.sv
// port-level checks for the reply crc checker, bound to the top level
`default_nettype none

module rcc_checker
   import rcc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_is_binary,
   input wire logic [15:0] rsp_computed_crc,
   input wire logic [15:0] rsp_received_crc,
   input wire logic [15:0] rsp_message_length
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_computed_crc) && $stable(rsp_received_crc)
         && $stable(rsp_message_length))
      else $error("result changed while stalled");

   // only defined status codes are reported
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 3'd6 && rsp_status != 3'd7)
      else $error("undefined status code");

   // header and body verdicts belong to binary replies, text verdicts to text replies
   a_format_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_HDR_BAD || rsp_status == ST_BODY_BAD) == 1'b0
                     || rsp_is_binary)
                 && ((rsp_status == ST_TEXT_BAD || rsp_status == ST_NO_CR
                      || rsp_status == ST_SHORT) == 1'b0 || !rsp_is_binary))
      else $error("status does not match reply format");

   // a missing carriage return reports the length limit and no crcs
   a_no_cr_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NO_CR |-> rsp_message_length == MAX_TEXT_LEN
         && rsp_computed_crc == 16'h0000 && rsp_received_crc == 16'h0000)
      else $error("bad fields on missing carriage return");

   // a short text reply has fewer than four characters
   a_short_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SHORT |-> rsp_message_length < 16'd4)
      else $error("short reply with long length");

endmodule

bind reply_crc_checker_top rcc_checker u_rcc_checker (.*);

`default_nettype wire

FILE: sim/reply_crc_checker_top_tb.sv
// self-checking testbench for the reply crc checker: framed text and binary replies
module reply_crc_checker_top_tb;
   import rcc_pkg::*;

   localparam int RANDOM_BYTES = 250;
   localparam int LONG_HOLD    = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_WAIT  = 8;

   // letter case of the hex digits in a text crc field
   localparam int CASE_UPPER = 0;
   localparam int CASE_LOWER = 1;
   localparam int CASE_MIXED = 2;

   typedef enum {CRC_GOOD, CRC_WRONG, CRC_NONHEX} text_crc_kind;
   typedef enum {BIN_CLEAN, BIN_HDR_FAULT, BIN_BODY_FAULT} bin_fault_kind;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_start_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic        rsp_is_binary;
   logic [15:0] rsp_computed_crc;
   logic [15:0] rsp_received_crc;
   logic [15:0] rsp_message_length;

   // framing state of the predictor
   phase_type   fr_phase;
   logic [15:0] fr_crc;
   logic [7:0]  fr_win [4];
   logic [15:0] fr_count;
   logic [15:0] fr_body_len;
   logic [15:0] fr_carried;
   logic        fr_hex_bad;

   result_type  expected_verdicts [$];
   logic [7:0]  msg_buf [$];

   int   mismatch_count = 0;
   int   quiet_cycles = 0;
   bit   idling_on = 1'b1;
   bit   sender_gappy = 1'b1;
   logic hold_req;
   logic sink_hold_done = 1'b0;

   reply_crc_checker_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_start_of_message (req_start_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_is_binary      (rsp_is_binary),
      .rsp_computed_crc   (rsp_computed_crc),
      .rsp_received_crc   (rsp_received_crc),
      .rsp_message_length (rsp_message_length)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // crc-16/arc, one byte, data bits taken lsb first
   function automatic logic [15:0] crc16_arc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ b[k]) r = (r >> 1) ^ CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

   // bit 4 flags a character that is not a hex digit
   function automatic logic [4:0] ascii_hex_digit(input logic [7:0] ch);
      if (ch inside {[8'h30:8'h39]}) return {1'b0, 4'(ch - 8'h30)};
      if (ch inside {[8'h61:8'h66]}) return {1'b0, 4'(ch - 8'h57)};
      if (ch inside {[8'h41:8'h46]}) return {1'b0, 4'(ch - 8'h37)};
      return 5'h10;
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (lower ? 8'h57 : 8'h37) + 8'(n);
   endfunction

   task automatic reset_predictor();
      fr_phase    = PH_IDLE;
      fr_crc      = '0;
      fr_win      = '{default: 8'h00};
      fr_count    = '0;
      fr_body_len = '0;
      fr_carried  = '0;
      fr_hex_bad  = 1'b0;
   endtask

   task automatic push_verdict(input status_type st, input logic bin, input logic [15:0] comp,
                               input logic [15:0] recv, input logic [15:0] len);
      result_type r;
      r.status         = st;
      r.is_binary      = bin;
      r.computed_crc   = comp;
      r.received_crc   = recv;
      r.message_length = len;
      expected_verdicts.push_back(r);
      fr_phase = PH_DONE;
   endtask

   // advance the framing state by one accepted byte and queue any verdict
   task automatic predict_reply_byte(input logic [7:0] b, input logic som);
      logic [15:0] rx;
      logic [4:0]  hv;
      logic        bad;
      if (som) begin
         reset_predictor();
         fr_phase = PH_TEXT;
      end
      case (fr_phase)
         PH_TEXT: begin
            if (fr_count == 16'd1 && fr_win[3] == BIN_SYNC0 && b == BIN_SYNC1) begin
               fr_phase = PH_BHDR;
               fr_crc   = crc16_arc_step(crc16_arc_step(16'h0000, BIN_SYNC0), BIN_SYNC1);
               fr_count = 16'd2;
            end else if (b == CR_CHAR) begin
               if (fr_count < 16'd4) begin
                  push_verdict(ST_SHORT, 1'b0, 16'h0000, 16'h0000, fr_count);
               end else begin
                  rx  = '0;
                  bad = 1'b0;
                  for (int k = 0; k < 4; k++) begin
                     hv = ascii_hex_digit(fr_win[k]);
                     if (hv[4]) begin
                        bad = 1'b1;
                        hv  = 5'h00;
                     end
                     rx = {rx[11:0], hv[3:0]};
                  end
                  fr_carried = rx;
                  fr_hex_bad = bad;
                  push_verdict((bad || rx != fr_crc) ? ST_TEXT_BAD : ST_OK, 1'b0,
                               fr_crc, rx, fr_count);
               end
            end else begin
               // the crc trails four characters behind, the window holds the crc field
               if (fr_count >= 16'd4) fr_crc = crc16_arc_step(fr_crc, fr_win[0]);
               fr_win[0] = fr_win[1];
               fr_win[1] = fr_win[2];
               fr_win[2] = fr_win[3];
               fr_win[3] = b;
               fr_count++;
               if (fr_count >= MAX_TEXT_LEN)
                  push_verdict(ST_NO_CR, 1'b0, 16'h0000, 16'h0000, MAX_TEXT_LEN);
            end
         end
         PH_BHDR: begin
            if (fr_count == 16'd2) begin
               fr_body_len = {8'h00, b};
               fr_crc      = crc16_arc_step(fr_crc, b);
               fr_count++;
            end else if (fr_count == 16'd3) begin
               fr_body_len[15:8] = b;
               fr_crc            = crc16_arc_step(fr_crc, b);
               fr_count++;
            end else if (fr_count == 16'd4) begin
               fr_carried = {8'h00, b};
               fr_count++;
            end else begin
               fr_carried[15:8] = b;
               if (fr_carried != fr_crc) begin
                  push_verdict(ST_HDR_BAD, 1'b1, fr_crc, fr_carried, fr_body_len);
               end else begin
                  fr_crc   = '0;
                  fr_count = '0;
                  fr_phase = (fr_body_len == 16'd0) ? PH_BTAIL : PH_BBODY;
               end
            end
         end
         PH_BBODY: begin
            fr_crc = crc16_arc_step(fr_crc, b);
            fr_count++;
            if (fr_count == fr_body_len) begin
               fr_count = '0;
               fr_phase = PH_BTAIL;
            end
         end
         PH_BTAIL: begin
            if (fr_count == 16'd0) begin
               fr_carried = {8'h00, b};
               fr_count   = 16'd1;
            end else begin
               fr_carried[15:8] = b;
               push_verdict((fr_carried != fr_crc) ? ST_BODY_BAD : ST_OK, 1'b1,
                            fr_crc, fr_carried, fr_body_len);
            end
         end
         default: ;
      endcase
   endtask

   // one byte transfer on the request channel
   task automatic send_reply_byte(input logic [7:0] data, input logic som);
      if (idling_on && sender_gappy && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data_byte        <= data;
      req_start_of_message <= som;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_reply_byte(data, som);
   endtask

   task automatic send_msg_buf();
      sender_gappy = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < msg_buf.size(); i++) send_reply_byte(msg_buf[i], i == 0);
      msg_buf.delete();
   endtask

   task automatic truncate_msg(input int keep);
      while (msg_buf.size() > keep) void'(msg_buf.pop_back());
   endtask

   // random text characters, never CR and never the binary sync pair up front
   task automatic append_text_body(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(0, 255));
         while (b == CR_CHAR || (msg_buf.size() == 1 && msg_buf[0] == BIN_SYNC0 &&
                b == BIN_SYNC1))
            b = 8'($urandom_range(0, 255));
         msg_buf.push_back(b);
      end
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) msg_buf.push_back(8'(s[i]));
   endtask

   // append the four crc characters and the CR terminator
   task automatic finish_text(input text_crc_kind kind, input int pos, input int letter_case);
      logic [15:0] c;
      logic [7:0]  junk;
      logic [4:0]  hv;
      bit          lower;
      c = '0;
      foreach (msg_buf[i]) c = crc16_arc_step(c, msg_buf[i]);
      if (kind == CRC_WRONG) c ^= 16'($urandom_range(1, 65535));
      for (int k = 3; k >= 0; k--) begin
         lower = (letter_case == CASE_LOWER) ||
                 (letter_case == CASE_MIXED && $urandom_range(0, 1) == 1);
         msg_buf.push_back(hex_ascii(c[k*4 +: 4], lower));
      end
      if (kind == CRC_NONHEX) begin
         junk = CR_CHAR;
         hv   = ascii_hex_digit(junk);
         while (junk == CR_CHAR || !hv[4]) begin
            junk = 8'($urandom_range(0, 255));
            hv   = ascii_hex_digit(junk);
         end
         msg_buf[msg_buf.size() - 4 + pos] = junk;
      end
      msg_buf.push_back(CR_CHAR);
   endtask

   // binary reply; body_bytes may differ from the length field for broken frames
   task automatic build_binary(input int len, input bin_fault_kind fault, input int body_bytes);
      logic [15:0] c;
      logic [15:0] len16;
      logic [7:0]  b;
      len16 = 16'(len);
      msg_buf.push_back(BIN_SYNC0);
      msg_buf.push_back(BIN_SYNC1);
      msg_buf.push_back(len16[7:0]);
      msg_buf.push_back(len16[15:8]);
      c = '0;
      foreach (msg_buf[i]) c = crc16_arc_step(c, msg_buf[i]);
      if (fault == BIN_HDR_FAULT) c ^= 16'($urandom_range(1, 65535));
      msg_buf.push_back(c[7:0]);
      msg_buf.push_back(c[15:8]);
      c = '0;
      for (int i = 0; i < body_bytes; i++) begin
         b = 8'($urandom_range(0, 255));
         msg_buf.push_back(b);
         c = crc16_arc_step(c, b);
      end
      if (fault == BIN_BODY_FAULT) c ^= 16'($urandom_range(1, 65535));
      if (fault != BIN_HDR_FAULT) begin
         msg_buf.push_back(c[7:0]);
         msg_buf.push_back(c[15:8]);
      end
   endtask

   task automatic wait_for_all_verdicts();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // bytes with no open message
   task automatic test_ignored_bytes();
      send_reply_byte(8'hFF, 1'b0);
      send_reply_byte(8'h00, 1'b0);
      send_reply_byte(CR_CHAR, 1'b0);
   endtask

   task automatic test_text_replies();
      push_string("STATUS 01");
      finish_text(CRC_GOOD, 0, CASE_UPPER);
      send_msg_buf();
      append_text_body(9);
      finish_text(CRC_GOOD, 0, CASE_LOWER);
      send_msg_buf();
      // byte extremes inside the checked range
      msg_buf = '{8'h00, 8'hFF, 8'h00, 8'hFF};
      finish_text(CRC_GOOD, 0, CASE_MIXED);
      send_msg_buf();
      // crc field only, crc over nothing
      finish_text(CRC_GOOD, 0, CASE_UPPER);
      send_msg_buf();
   endtask

   task automatic test_text_errors();
      logic [15:0] c;
      append_text_body(12);
      finish_text(CRC_WRONG, 0, CASE_MIXED);
      send_msg_buf();
      append_text_body(7);
      finish_text(CRC_NONHEX, 3, CASE_UPPER);
      send_msg_buf();
      // non-hex digit standing for a zero nibble, values still agree
      c = 16'hFFFF;
      while (c[15:12] != 4'h0) begin
         msg_buf.delete();
         append_text_body(6);
         c = '0;
         foreach (msg_buf[i]) c = crc16_arc_step(c, msg_buf[i]);
      end
      finish_text(CRC_NONHEX, 0, CASE_UPPER);
      send_msg_buf();
      // too short: CR as the first byte, then two and three characters
      send_reply_byte(CR_CHAR, 1'b1);
      push_string("AB");
      msg_buf.push_back(CR_CHAR);
      send_msg_buf();
      append_text_body(3);
      msg_buf.push_back(CR_CHAR);
      send_msg_buf();
      // no CR within the maximum length, later bytes fall outside a message
      append_text_body(int'(MAX_TEXT_LEN));
      send_msg_buf();
      send_reply_byte(CR_CHAR, 1'b0);
      send_reply_byte(8'h41, 1'b0);
   endtask

   task automatic test_binary_replies();
      build_binary(0, BIN_CLEAN, 0);
      send_msg_buf();
      build_binary(1, BIN_CLEAN, 1);
      send_msg_buf();
      build_binary(40, BIN_CLEAN, 40);
      send_msg_buf();
      build_binary(3, BIN_BODY_FAULT, 3);
      send_msg_buf();
      // bad header at the largest length; trailing bytes are ignored
      build_binary(65535, BIN_HDR_FAULT, 4);
      send_msg_buf();
      build_binary(0, BIN_BODY_FAULT, 0);
      send_msg_buf();
   endtask

   task automatic test_framing_edges();
      // new start aborts a text message and a binary body
      append_text_body(6);
      send_msg_buf();
      build_binary(5, BIN_CLEAN, 5);
      truncate_msg(8);
      send_msg_buf();
      // sync bytes that do not select binary
      msg_buf = '{BIN_SYNC0, 8'h41};
      append_text_body(3);
      finish_text(CRC_GOOD, 0, CASE_MIXED);
      send_msg_buf();
      msg_buf = '{BIN_SYNC1, BIN_SYNC0};
      finish_text(CRC_GOOD, 0, CASE_MIXED);
      send_msg_buf();
      msg_buf = '{8'h58, BIN_SYNC0, BIN_SYNC1};
      append_text_body(2);
      finish_text(CRC_GOOD, 0, CASE_MIXED);
      send_msg_buf();
      msg_buf = '{BIN_SYNC0, CR_CHAR};
      send_msg_buf();
      // binary sync with start flag on the second byte too
      send_reply_byte(BIN_SYNC0, 1'b1);
      send_reply_byte(BIN_SYNC1, 1'b1);
      send_reply_byte(CR_CHAR, 1'b0);
   endtask

   task automatic test_random_traffic();
      int sent;
      int pick;
      int n;
      int len;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         n    = $urandom_range(0, 19);
         len  = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 320) : $urandom_range(0, 12);
         msg_buf.delete();
         if (pick < 40) begin
            append_text_body($urandom_range(0, 24));
            finish_text(n < 14 ? CRC_GOOD : (n < 17 ? CRC_WRONG : CRC_NONHEX),
                        $urandom_range(0, 3), CASE_MIXED);
         end else if (pick < 50) begin
            append_text_body($urandom_range(0, 3));
            msg_buf.push_back(CR_CHAR);
         end else if (pick < 80) begin
            build_binary(len, n < 14 ? BIN_CLEAN : (n < 17 ? BIN_HDR_FAULT : BIN_BODY_FAULT),
                         (n >= 14 && n < 17) ? $urandom_range(0, 3) : len);
         end else if (pick < 90) begin
            // broken frame, cut short before its end
            if (pick < 85) begin
               append_text_body($urandom_range(0, 16));
               finish_text(CRC_GOOD, 0, CASE_MIXED);
            end else begin
               build_binary(len, BIN_CLEAN, len);
            end
            truncate_msg($urandom_range(1, msg_buf.size() - 1));
         end else begin
            for (int i = 0; i < $urandom_range(1, 8); i++)
               send_reply_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
         end
         sent += msg_buf.size();
         send_msg_buf();
      end
   endtask

   // receiver holds off while short replies keep coming
   task automatic test_output_backpressure();
      hold_req <= 1'b1;
      for (int i = 0; i < 30; i++) begin
         append_text_body($urandom_range(0, 3));
         msg_buf.push_back(CR_CHAR);
         send_msg_buf();
      end
      while (!sink_hold_done) @(posedge clock);
      hold_req <= 1'b0;
   endtask

   // sender waits for every verdict before going on
   task automatic test_drain_pause();
      build_binary(4, BIN_CLEAN, 4);
      send_msg_buf();
      append_text_body(5);
      finish_text(CRC_GOOD, 0, CASE_MIXED);
      send_msg_buf();
      wait_for_all_verdicts();
      append_text_body(5);
      finish_text(CRC_WRONG, 0, CASE_MIXED);
      send_msg_buf();
   endtask

   // closing stretch without idling, longer binary body
   task automatic test_long_body();
      idling_on = 1'b0;
      for (int i = 0; i < 10; i++) begin
         append_text_body($urandom_range(0, 10));
         finish_text(CRC_GOOD, 0, CASE_MIXED);
         send_msg_buf();
      end
      build_binary(200, BIN_CLEAN, 200);
      send_msg_buf();
      build_binary(2, BIN_BODY_FAULT, 2);
      send_msg_buf();
   endtask

   // main sequence
   initial begin
      req_valid            <= 1'b0;
      req_data_byte        <= 8'h00;
      req_start_of_message <= 1'b0;
      hold_req             <= 1'b0;
      reset                <= 1'b1;
      reset_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_ignored_bytes();
      test_text_replies();
      test_text_errors();
      test_binary_replies();
      test_framing_edges();
      test_random_traffic();
      test_output_backpressure();
      test_drain_pause();
      test_long_body();
      wait_for_all_verdicts();
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // result receiver: random stall bursts, calm stretches, one long hold on request
   initial begin : result_sink
      int gap_left;
      int hold_left;
      int calm_left;
      bit hold_started;
      gap_left     = 0;
      hold_left    = 0;
      calm_left    = 0;
      hold_started = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_req) begin
            hold_started = 1'b0;
            if (sink_hold_done) sink_hold_done <= 1'b0;
         end else if (!hold_started) begin
            hold_started = 1'b1;
            hold_left    = LONG_HOLD;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
            if (hold_left == 0) sink_hold_done <= 1'b1;
         end else if (gap_left != 0) begin
            rsp_ready <= 1'b0;
            gap_left--;
         end else begin
            if (calm_left != 0) calm_left--;
            else if (idling_on && $urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
            if (idling_on && calm_left == 0 && $urandom_range(0, 4) == 0) begin
               rsp_ready <= 1'b0;
               gap_left = $urandom_range(0, 3);
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // compare each result transfer with the oldest expected verdict
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result: status %0d length %0d", rsp_status, rsp_message_length);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_status !== 3'(want.status)) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_is_binary !== want.is_binary) begin
               $error("is_binary: expected %0d, got %0d", want.is_binary, rsp_is_binary);
               mismatch_count++;
            end
            if (rsp_computed_crc !== want.computed_crc) begin
               $error("computed_crc: expected %h, got %h", want.computed_crc, rsp_computed_crc);
               mismatch_count++;
            end
            if (rsp_received_crc !== want.received_crc) begin
               $error("received_crc: expected %h, got %h", want.received_crc, rsp_received_crc);
               mismatch_count++;
            end
            if (rsp_message_length !== want.message_length) begin
               $error("message_length: expected %0d, got %0d",
                      want.message_length, rsp_message_length);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
